// ===== sv/u2h_pkg.sv =====
// Types, constants and helpers shared by the UTF-8 to HTML character reference block.
// No dependencies.
package u2h_pkg;

  localparam int unsigned CodeW = 21;
  localparam int unsigned NibW  = 3;

  localparam logic [CodeW-1:0] CodeMax  = 21'h10FFFF;
  localparam logic [CodeW-1:0] RawLimit = 21'h00007E;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChX    = 8'h78;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChLowA = 8'h61;

  typedef enum logic [1:0] {
    EV_RAW = 2'd0,
    EV_ENT = 2'd1,
    EV_ERR = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e          kind;
    logic [NibW-1:0]   top_nib;
    logic [CodeW-1:0]  code;
  } ev_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + {4'b0, d};
    end else begin
      c = ChLowA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== sv/u2h_if.sv =====
// Handshake channels of the UTF-8 to HTML character reference block.
// No dependencies.
interface u2h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u2h_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;
  logic       seq_error;

  modport source (output valid, output out_char, output last_of_run, output seq_error,
                  input ready);
  modport sink   (input valid, input out_char, input last_of_run, input seq_error,
                  output ready);
endinterface

// ===== sv/u2h_front.sv =====
// Front end: takes UTF-8 bytes, gathers sequences and classifies each finished one.
// Depends on u2h_pkg.
module u2h_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   in_byte_i,
  input  logic                         string_end_i,
  output logic                         ev_valid_o,
  output u2h_pkg::ev_t                 ev_o
);

  logic [u2h_pkg::CodeW-1:0] acc_q, acc_d;
  logic [1:0]                pend_q, pend_d;
  logic [2:0]                total_q, total_d;

  logic [u2h_pkg::CodeW-1:0] acc_next;
  logic [1:0]                pend_next;
  logic [u2h_pkg::CodeW-1:0] code;
  logic                      emit_code;
  logic                      emit_err;
  logic [23:0]               code_pad;
  logic [u2h_pkg::NibW-1:0]  top_nib;
  logic                      is_raw;

  assign acc_next  = {acc_q[u2h_pkg::CodeW-7:0], in_byte_i[5:0]};
  assign pend_next = pend_q - 2'd1;

  always_comb begin
    acc_d     = acc_q;
    pend_d    = pend_q;
    total_d   = total_q;
    code      = {13'b0, in_byte_i};
    emit_code = 1'b0;
    emit_err  = 1'b0;
    if (pend_q == 2'd0) begin
      if (in_byte_i < 8'h80) begin
        emit_code = 1'b1;
      end else if (in_byte_i inside {[8'hC0:8'hDF]}) begin
        acc_d   = {16'b0, in_byte_i[4:0]};
        pend_d  = 2'd1;
        total_d = 3'd2;
        emit_err = string_end_i;
      end else if (in_byte_i inside {[8'hE0:8'hEF]}) begin
        acc_d   = {17'b0, in_byte_i[3:0]};
        pend_d  = 2'd2;
        total_d = 3'd3;
        emit_err = string_end_i;
      end else if (in_byte_i inside {[8'hF0:8'hF7]}) begin
        acc_d   = {18'b0, in_byte_i[2:0]};
        pend_d  = 2'd3;
        total_d = 3'd4;
        emit_err = string_end_i;
      end else begin
        emit_err = 1'b1;
      end
    end else if (in_byte_i[7:6] != 2'b10) begin
      emit_err = 1'b1;
    end else begin
      acc_d  = acc_next;
      pend_d = pend_next;
      code   = acc_next;
      if (pend_next == 2'd0) begin
        if (total_q == 3'd4 && acc_next > u2h_pkg::CodeMax) begin
          emit_err = 1'b1;
        end else begin
          emit_code = 1'b1;
        end
      end else begin
        emit_err = string_end_i;
      end
    end
    if (emit_err || emit_code) begin
      acc_d   = '0;
      pend_d  = 2'd0;
      total_d = 3'd0;
    end
  end

  assign code_pad = {3'b0, code};

  always_comb begin
    top_nib = '0;
    for (int i = 0; i < 6; i++) begin
      if (code_pad[4*i +: 4] != 4'd0) begin
        top_nib = u2h_pkg::NibW'(i);
      end
    end
  end

  assign is_raw = (code < u2h_pkg::RawLimit) && (code != '0) &&
                  !(code[7:0] inside {u2h_pkg::ChLt, u2h_pkg::ChGt,
                                      u2h_pkg::ChQuot, u2h_pkg::ChAmp});

  always_comb begin
    ev_valid_o = accept_i && (emit_err || emit_code);
    ev_o.code    = code;
    ev_o.top_nib = top_nib;
    if (emit_err) begin
      ev_o.kind = u2h_pkg::EV_ERR;
    end else if (is_raw) begin
      ev_o.kind = u2h_pkg::EV_RAW;
    end else begin
      ev_o.kind = u2h_pkg::EV_ENT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pend_q  <= 2'd0;
      total_q <= 3'd0;
    end else if (accept_i) begin
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      total_q <= total_d;
    end
  end

endmodule

// ===== sv/u2h_fifo.sv =====
// Short event queue between the decode front end and the character sequencer.
// Depends on u2h_pkg.
module u2h_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  u2h_pkg::ev_t push_data_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output u2h_pkg::ev_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u2h_pkg::ev_t    mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/u2h_back.sv =====
// Back end: expands each queued event into output characters, one per cycle while the output is ready.
// Depends on u2h_pkg and u2h_out_if.
module u2h_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         ev_avail_i,
  input  u2h_pkg::ev_t ev_i,
  output logic         ev_pop_o,
  u2h_out_if.source    out_o
);

  localparam logic [2:0] PhAmp  = 3'd0;
  localparam logic [2:0] PhHash = 3'd1;
  localparam logic [2:0] PhX    = 3'd2;
  localparam logic [2:0] PhDig  = 3'd3;
  localparam logic [2:0] PhSemi = 3'd4;

  logic                     busy_q, busy_d;
  u2h_pkg::ev_t             ev_q;
  logic [2:0]               ph_q, ph_d;
  logic [u2h_pkg::NibW-1:0] nib_q, nib_d;
  logic                     ovalid_q, ovalid_d;
  logic [7:0]               ochar_q;
  logic                     olast_q;
  logic                     oerr_q;

  logic                     adv;
  logic                     load;
  logic [7:0]               cur_char;
  logic                     cur_last;
  logic                     cur_err;
  logic [23:0]              code_pad;
  logic [3:0]               digit;

  assign code_pad = {3'b0, ev_q.code};
  assign digit    = code_pad[4*nib_q +: 4];

  always_comb begin
    cur_char = 8'h00;
    cur_last = 1'b1;
    cur_err  = 1'b0;
    case (ev_q.kind)
      u2h_pkg::EV_RAW: begin
        cur_char = ev_q.code[7:0];
      end
      u2h_pkg::EV_ERR: begin
        cur_err = 1'b1;
      end
      u2h_pkg::EV_ENT: begin
        cur_last = 1'b0;
        case (ph_q)
          PhAmp:   cur_char = u2h_pkg::ChAmp;
          PhHash:  cur_char = u2h_pkg::ChHash;
          PhX:     cur_char = u2h_pkg::ChX;
          PhDig:   cur_char = u2h_pkg::hex_char(digit);
          default: begin
            cur_char = u2h_pkg::ChSemi;
            cur_last = 1'b1;
          end
        endcase
      end
      default: begin
        cur_err = 1'b1;
      end
    endcase
  end

  assign adv      = busy_q && (!ovalid_q || out_o.ready);
  assign load     = ev_avail_i && (!busy_q || (adv && cur_last));
  assign ev_pop_o = load;

  always_comb begin
    ph_d  = ph_q;
    nib_d = nib_q;
    if (adv && !cur_last) begin
      case (ph_q)
        PhAmp:  ph_d = PhHash;
        PhHash: ph_d = PhX;
        PhX:    ph_d = PhDig;
        PhDig: begin
          if (nib_q == '0) begin
            ph_d = PhSemi;
          end else begin
            nib_d = nib_q - 1'b1;
          end
        end
        default: ph_d = PhSemi;
      endcase
    end
    if (load) begin
      ph_d  = PhAmp;
      nib_d = ev_i.top_nib;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (adv && cur_last) begin
      busy_d = 1'b0;
    end
    ovalid_d = ovalid_q;
    if (adv) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ph_q     <= PhAmp;
      nib_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ph_q     <= ph_d;
      nib_q    <= nib_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q <= ev_i;
    end
    if (adv) begin
      ochar_q <= cur_char;
      olast_q <= cur_last;
      oerr_q  <= cur_err;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_char    = ochar_q;
  assign out_o.last_of_run = olast_q;
  assign out_o.seq_error   = oerr_q;

endmodule

// ===== sv/utf8_to_html_char_ref.sv =====
// Top level of the UTF-8 to HTML numeric character reference converter.
// Depends on u2h_pkg, u2h_in_if, u2h_out_if, u2h_front, u2h_fifo and u2h_back.
//
// Takes one UTF-8 byte per cycle and emits a character below 0x7E other than NUL,
// <, >, double quote and & as itself, anything else as "&#x<hex>;" (5 to 10
// characters), and a single error item for a bad or truncated sequence. The input
// side accepts a byte every cycle while the event queue (FifoDepth entries) has
// room; the back-end sequencer sets the output rate, one character per cycle while
// the output is ready, and the queue absorbs entity bursts. A plain character
// passes a queue entry, the event register and the output register.
module utf8_to_html_char_ref #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2h_in_if.sink    in_i,
  u2h_out_if.source out_o
);

  logic         accept;
  logic         ev_valid;
  u2h_pkg::ev_t ev;
  logic         q_full;
  logic         q_empty;
  u2h_pkg::ev_t q_head;
  logic         q_pop;

  assign in_i.ready = !q_full;
  assign accept     = in_i.valid && !q_full;

  u2h_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_i.in_byte),
    .string_end_i (in_i.string_end),
    .ev_valid_o   (ev_valid),
    .ev_o         (ev)
  );

  u2h_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ev_valid),
    .push_data_i (ev),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  u2h_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_avail_i (!q_empty),
    .ev_i       (q_head),
    .ev_pop_o   (q_pop),
    .out_o      (out_o)
  );

endmodule
